// File: rtl/kbeq_pkg.sv
// ----------------------------------------------------------------------------
// Keyboard event encoder queue package
// Shared widths, operation codes, the key translation tables and the
// decoder output record.
// ----------------------------------------------------------------------------
package kbeq_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned CODE_W     = 18;
  localparam int unsigned STATE_W    = 19;
  localparam int unsigned LOCK_W     = 3;
  localparam int unsigned MOD_W      = 6;
  localparam int unsigned SPEC_IDX_W = 6;

  // Operation codes carried by op_i.
  typedef enum logic [OP_W-1:0] {
    OP_KEY_DOWN = 3'd0,
    OP_KEY_UP   = 3'd1,
    OP_CHAR     = 3'd2,
    OP_READ     = 3'd3,
    OP_FLUSH    = 3'd4
  } op_e;

  // Key codes with special handling.
  localparam logic [KEY_W-1:0] KEY_NUM    = 16'h0090;
  localparam logic [KEY_W-1:0] KEY_SCROLL = 16'h0091;
  localparam logic [KEY_W-1:0] KEY_CAPS   = 16'h0014;

  localparam logic [KEY_W-1:0] CTRL_CHAR_LIMIT = 16'h001b;
  localparam logic [KEY_W-1:0] CTRL_CHAR_OFS   = 16'h0060;

  // State update and queue request produced by the decoder for one request.
  typedef struct packed {
    logic [STATE_W-1:0]    mask_d;
    logic [LOCK_W-1:0]     latch_d;
    logic                  push;
    logic [CODE_W-1:0]     push_code;
    logic                  spec_we;
    logic                  spec_val;
    logic [SPEC_IDX_W-1:0] spec_idx;
  } upd_t;

  // Modifier bits set or cleared by a modifier key.
  function automatic logic [MOD_W-1:0] modifier_bits(logic [KEY_W-1:0] k);
    logic [MOD_W-1:0] m;
    case (k)
      16'h00a0: m = 6'h01;
      16'h0010: m = 6'h03;
      16'h00a1: m = 6'h02;
      16'h00a4: m = 6'h10;
      16'h0012: m = 6'h30;
      16'h00a5: m = 6'h20;
      16'h00a2: m = 6'h04;
      16'h0011: m = 6'h0c;
      16'h00a3: m = 6'h08;
      default:  m = '0;
    endcase
    return m;
  endfunction

  // Numeric keypad digits and decimal point.
  function automatic logic [CODE_W-1:0] numpad_code(logic [KEY_W-1:0] k);
    logic [CODE_W-1:0] c;
    case (k)
      16'h0060: c = 18'h10007;
      16'h0061: c = 18'h10018;
      16'h0062: c = 18'h10019;
      16'h0063: c = 18'h1001a;
      16'h0064: c = 18'h10014;
      16'h0065: c = 18'h10015;
      16'h0066: c = 18'h10016;
      16'h0067: c = 18'h10010;
      16'h0068: c = 18'h10011;
      16'h0069: c = 18'h10012;
      16'h006e: c = 18'h10006;
      default:  c = '0;
    endcase
    return c;
  endfunction

  // Navigation keys, shared by press and release.
  function automatic logic [CODE_W-1:0] nav_code(logic [KEY_W-1:0] k);
    logic [CODE_W-1:0] c;
    case (k)
      16'h002e: c = 18'h10006;
      16'h002d: c = 18'h10007;
      16'h0024: c = 18'h10010;
      16'h0023: c = 18'h10018;
      16'h0021: c = 18'h10012;
      16'h0022: c = 18'h1001a;
      16'h0025: c = 18'h10014;
      16'h0027: c = 18'h10016;
      16'h0026: c = 18'h10011;
      16'h0028: c = 18'h10019;
      16'h0029: c = 18'h10015;
      default:  c = '0;
    endcase
    return c;
  endfunction

  // Event code for a pressed key; zero means nothing is queued.
  function automatic logic [CODE_W-1:0] press_code(logic [KEY_W-1:0] k);
    logic [CODE_W-1:0] c;
    case (k)
      16'h0020:           c = 18'h00020;
      16'h001b:           c = 18'h10000;
      16'h000d, 16'h006c: c = 18'h10001;
      16'h0009:           c = 18'h10002;
      16'h0008:           c = 18'h10003;
      16'h002a, 16'h002c: c = 18'h10004;
      16'h002b, 16'h0013: c = 18'h10005;
      16'h006a:           c = 18'h0002a;
      16'h006f:           c = 18'h0002f;
      16'h006b:           c = 18'h0002b;
      16'h006d:           c = 18'h0002d;
      default: begin
        c = nav_code(k);
        if (c == '0) begin
          if (k >= 16'h0070 && k <= 16'h007b) begin
            c = 18'h20001 + CODE_W'(k - 16'h0070);
          end else if (k >= 16'h0030 && k <= 16'h0039) begin
            c = 18'h30000 + CODE_W'(k);
          end else if (k >= 16'h0041 && k <= 16'h005a) begin
            c = 18'h30020 + CODE_W'(k);
          end else begin
            c = numpad_code(k);
          end
        end
      end
    endcase
    return c;
  endfunction

endpackage

// File: rtl/kbeq_keymap.sv
// ----------------------------------------------------------------------------
// Keyboard event key decoder
// Turns one request and the current modifier and lock state into the next
// state, an optional queue push and an optional special-key flag update.
// ----------------------------------------------------------------------------
module kbeq_keymap (
  input  logic [kbeq_pkg::OP_W-1:0]    op_i,
  input  logic [kbeq_pkg::KEY_W-1:0]   key_i,
  input  logic [kbeq_pkg::STATE_W-1:0] mask_i,
  input  logic [kbeq_pkg::LOCK_W-1:0]  latch_i,
  output kbeq_pkg::upd_t               upd_o
);
  import kbeq_pkg::*;

  logic [MOD_W-1:0]  mod_bits;
  logic [LOCK_W-1:0] lock_oh;
  logic [CODE_W-1:0] down_code;
  logic [CODE_W-1:0] up_code;
  logic [KEY_W-1:0]  char_code;

  // Table lookups for the current key.
  assign mod_bits  = modifier_bits(key_i);
  assign lock_oh   = {key_i == KEY_CAPS, key_i == KEY_SCROLL, key_i == KEY_NUM};
  assign down_code = press_code(key_i);
  assign up_code   = (nav_code(key_i) != '0) ? nav_code(key_i) : numpad_code(key_i);

  // Control characters below escape move up by 0x60 while ctrl is held.
  assign char_code = ((|mask_i[3:2]) && (key_i < CTRL_CHAR_LIMIT)) ?
                     (key_i + CTRL_CHAR_OFS) : key_i;

  // Per-operation state update.
  always_comb begin
    upd_o           = '0;
    upd_o.mask_d    = mask_i;
    upd_o.latch_d   = latch_i;
    case (op_e'(op_i))
      OP_KEY_DOWN: begin
        if (mod_bits != '0) begin
          upd_o.mask_d[MOD_W-1:0] = mask_i[MOD_W-1:0] | mod_bits;
        end else if (lock_oh != '0) begin
          // A lock key toggles its state bit only once per latch set.
          if ((latch_i & lock_oh) == '0) begin
            upd_o.latch_d       = latch_i | lock_oh;
            upd_o.mask_d[18:16] = mask_i[18:16] ^ lock_oh;
          end
        end else if (down_code != '0) begin
          upd_o.push      = 1'b1;
          upd_o.push_code = down_code;
          upd_o.spec_we   = (down_code[17:16] == 2'b01) &&
                            (down_code[15:SPEC_IDX_W] == '0);
          upd_o.spec_val  = 1'b1;
          upd_o.spec_idx  = down_code[SPEC_IDX_W-1:0];
        end
      end
      OP_KEY_UP: begin
        if (mod_bits != '0) begin
          upd_o.mask_d[MOD_W-1:0] = mask_i[MOD_W-1:0] & ~mod_bits;
          // Releasing any shift key also drops the caps state.
          if (|mod_bits[1:0]) begin
            upd_o.mask_d[18] = 1'b0;
          end
        end else if (key_i == KEY_NUM) begin
          upd_o.latch_d[0] = 1'b0;
        end else if (key_i == KEY_SCROLL) begin
          upd_o.latch_d[1] = 1'b0;
        end else begin
          upd_o.spec_we  = (up_code[17:16] == 2'b01) &&
                           (up_code[15:SPEC_IDX_W] == '0);
          upd_o.spec_val = 1'b0;
          upd_o.spec_idx = up_code[SPEC_IDX_W-1:0];
        end
      end
      OP_CHAR: begin
        upd_o.push      = 1'b1;
        upd_o.push_code = CODE_W'(char_code);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/keyboard_event_encoder_queue.sv
// ----------------------------------------------------------------------------
// Keyboard event encoder queue
// Encodes key, character, read and flush requests into a ring of events
// and returns one result per request.
// ----------------------------------------------------------------------------
// The result of a request is registered and shown in the cycle after it is accepted.
// Throughput: one request per cycle while results are taken; the ring has one
// write and one read port, and the registered read data feeds the result directly.
// Reset clears the pointers, modifier mask, lock latches and special-key
// flags at once; ring contents are not cleared and need no clearing pass.
module keyboard_event_encoder_queue #(
  parameter int unsigned RING_DEPTH   = 64,
  parameter int unsigned SPECIAL_KEYS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [kbeq_pkg::OP_W-1:0]      op_i,
  input  logic [kbeq_pkg::KEY_W-1:0]     code_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           event_valid_o,
  output logic                           ring_empty_o,
  output logic [kbeq_pkg::CODE_W-1:0]    event_code_o,
  output logic [kbeq_pkg::STATE_W-1:0]   event_state_o
);
  import kbeq_pkg::*;

  localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  logic [CODE_W+STATE_W-1:0] ring_mem [RING_DEPTH];

  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [STATE_W-1:0] mask_q;
  logic [LOCK_W-1:0]  latch_q;
  logic [SPECIAL_KEYS-1:0] spec_q, spec_d;
  logic               out_valid_q;
  logic               ev_valid_q;
  logic               empty_q;
  logic [CODE_W+STATE_W-1:0] rd_data_q;

  logic  accept;
  logic  is_read;
  logic  is_flush;
  logic  ring_empty;
  logic  rd_en;
  upd_t  upd;

  // Key translation and state update.
  kbeq_keymap u_keymap (
    .op_i    (op_i),
    .key_i   (code_i),
    .mask_i  (mask_q),
    .latch_i (latch_q),
    .upd_o   (upd)
  );

  // A new request enters whenever the result register is free or drains.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_read    = (op_e'(op_i) == OP_READ);
  assign is_flush   = (op_e'(op_i) == OP_FLUSH);
  assign ring_empty = (rd_ptr_q == wr_ptr_q);
  assign rd_en      = accept && is_read && !ring_empty;

  // Pointer updates; a push always advances, even over unread events.
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    if (accept) begin
      if (upd.push) begin
        wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end else if (is_flush) begin
        wr_ptr_d = rd_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  // Special-key flags: one entry written per request at most.
  always_comb begin
    spec_d = spec_q;
    for (int i = 0; i < SPECIAL_KEYS; i++) begin
      if (accept && upd.spec_we && (upd.spec_idx == SPEC_IDX_W'(i))) begin
        spec_d[i] = upd.spec_val;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      mask_q      <= '0;
      latch_q     <= '0;
      spec_q      <= '0;
      out_valid_q <= 1'b0;
      ev_valid_q  <= 1'b0;
      empty_q     <= 1'b0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      spec_q   <= spec_d;
      if (accept) begin
        mask_q      <= upd.mask_d;
        latch_q     <= upd.latch_d;
        out_valid_q <= 1'b1;
        ev_valid_q  <= is_read && !ring_empty;
        empty_q     <= is_read && ring_empty;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Event ring: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (accept && upd.push) begin
      ring_mem[wr_ptr_q] <= {upd.push_code, mask_q};
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_ptr_q];
    end
  end

  // Result fields are zero unless an event was returned.
  assign out_valid_o   = out_valid_q;
  assign event_valid_o = ev_valid_q;
  assign ring_empty_o  = empty_q;
  assign event_code_o  = ev_valid_q ? rd_data_q[CODE_W+STATE_W-1:STATE_W] : '0;
  assign event_state_o = ev_valid_q ? rd_data_q[STATE_W-1:0] : '0;

endmodule

// File: rtl/kbeq_checker.sv
// ----------------------------------------------------------------------------
// Keyboard event encoder queue checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module kbeq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           event_valid_o,
  input logic                           ring_empty_o,
  input logic [kbeq_pkg::CODE_W-1:0]    event_code_o,
  input logic [kbeq_pkg::STATE_W-1:0]   event_state_o
);
  import kbeq_pkg::*;

  // Every accepted request leaves a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted request produced no result");

  // A free result register always takes a new request.
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

  // A read result is either an event or an empty flag, never both.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(event_valid_o && ring_empty_o))
    else $error("event and empty flags both set");

  // Without an event the payload fields are zero.
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !event_valid_o) |-> (event_code_o == '0 && event_state_o == '0))
    else $error("payload not zero without an event");

  // A stalled result holds its payload.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(event_code_o) && $stable(event_state_o)))
    else $error("stalled result changed");

endmodule

bind keyboard_event_encoder_queue kbeq_checker u_kbeq_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyboard event encoder queue testbench
// Drives key, character, read and flush requests through the valid/ready
// handshakes and checks every result against an in-bench model of the
// modifier state, lock latches and event ring.
// ----------------------------------------------------------------------------
module tb_top;
  import kbeq_pkg::*;

  localparam int unsigned RING_DEPTH   = 64;
  localparam int unsigned SPECIAL_KEYS = 32;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned LOCK_LSB     = 16;
  localparam int unsigned CAPS_BIT     = 18;

  // Operation codes outside the defined set; the block must ignore them.
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

  // Keys used by name in the directed part.
  localparam logic [KEY_W-1:0] VK_SHIFT = 16'h0010;
  localparam logic [KEY_W-1:0] VK_CTRL  = 16'h0011;
  localparam logic [KEY_W-1:0] VK_ESC   = 16'h001b;
  localparam logic [KEY_W-1:0] VK_A     = 16'h0041;
  localparam logic [KEY_W-1:0] VK_F12   = 16'h007b;
  localparam logic [KEY_W-1:0] VK_PAD0  = 16'h0060;

  // Key pools for the random part.
  localparam logic [KEY_W-1:0] MODIFIER_KEYS [9] = '{
    16'h00a0, 16'h0010, 16'h00a1, 16'h00a4, 16'h0012,
    16'h00a5, 16'h00a2, 16'h0011, 16'h00a3
  };
  localparam logic [KEY_W-1:0] LOCK_KEYS [3] = '{KEY_NUM, KEY_SCROLL, KEY_CAPS};
  localparam logic [KEY_W-1:0] ODD_KEYS [8] = '{
    16'h0008, 16'h0009, 16'h000d, 16'h0013, 16'h001b, 16'h006c, 16'h002a, 16'h002c
  };

  // One result as seen on the output channel.
  typedef struct packed {
    logic               ev_valid;
    logic               empty;
    logic [CODE_W-1:0]  code;
    logic [STATE_W-1:0] state;
  } event_result_t;

  // Model of the encoder: modifier state, lock latches and the event ring,
  // together with the results still owed by the block.
  class key_event_ring_model;
    logic [CODE_W-1:0]       ring_code [RING_DEPTH];
    logic [STATE_W-1:0]      ring_state [RING_DEPTH];
    int unsigned             rd_ptr;
    int unsigned             wr_ptr;
    logic [STATE_W-1:0]      mod_mask;
    logic [LOCK_W-1:0]       lock_latch;
    logic [SPECIAL_KEYS-1:0] special_down;
    event_result_t           pending_events[$];
    int unsigned             mismatches;

    function new();
      rd_ptr       = 0;
      wr_ptr       = 0;
      mod_mask     = '0;
      lock_latch   = '0;
      special_down = '0;
      mismatches   = 0;
    endfunction

    function logic [MOD_W-1:0] mod_bits(logic [KEY_W-1:0] k);
      case (k)
        16'h00a0: return 6'h01;
        16'h0010: return 6'h03;
        16'h00a1: return 6'h02;
        16'h00a4: return 6'h10;
        16'h0012: return 6'h30;
        16'h00a5: return 6'h20;
        16'h00a2: return 6'h04;
        16'h0011: return 6'h0c;
        16'h00a3: return 6'h08;
        default:  return '0;
      endcase
    endfunction

    // Slot of a lock key in the latches, or -1 for any other key.
    function int lock_slot(logic [KEY_W-1:0] k);
      if (k == KEY_NUM) return 0;
      if (k == KEY_SCROLL) return 1;
      if (k == KEY_CAPS) return 2;
      return -1;
    endfunction

    function logic [CODE_W-1:0] nav_event(logic [KEY_W-1:0] k);
      case (k)
        16'h002e: return 18'h10006;
        16'h002d: return 18'h10007;
        16'h0024: return 18'h10010;
        16'h0023: return 18'h10018;
        16'h0021: return 18'h10012;
        16'h0022: return 18'h1001a;
        16'h0025: return 18'h10014;
        16'h0027: return 18'h10016;
        16'h0026: return 18'h10011;
        16'h0028: return 18'h10019;
        16'h0029: return 18'h10015;
        default:  return '0;
      endcase
    endfunction

    function logic [CODE_W-1:0] keypad_event(logic [KEY_W-1:0] k);
      logic [CODE_W-1:0] digit_code [10];
      digit_code = '{18'h10007, 18'h10018, 18'h10019, 18'h1001a, 18'h10014,
                     18'h10015, 18'h10016, 18'h10010, 18'h10011, 18'h10012};
      if (k >= 16'h0060 && k <= 16'h0069) return digit_code[k - 16'h0060];
      if (k == 16'h006e) return 18'h10006;
      return '0;
    endfunction

    // Event code queued by a key press; zero when the key queues nothing.
    function logic [CODE_W-1:0] press_event(logic [KEY_W-1:0] k);
      logic [CODE_W-1:0] c;
      case (k)
        16'h0020:           return 18'h00020;
        16'h001b:           return 18'h10000;
        16'h000d, 16'h006c: return 18'h10001;
        16'h0009:           return 18'h10002;
        16'h0008:           return 18'h10003;
        16'h002a, 16'h002c: return 18'h10004;
        16'h002b, 16'h0013: return 18'h10005;
        16'h006a:           return 18'h0002a;
        16'h006f:           return 18'h0002f;
        16'h006b:           return 18'h0002b;
        16'h006d:           return 18'h0002d;
        default: ;
      endcase
      c = nav_event(k);
      if (c != '0) return c;
      if (k >= 16'h0070 && k <= 16'h007b) return 18'h20001 + CODE_W'(k - 16'h0070);
      if (k >= 16'h0030 && k <= 16'h0039) return 18'h30000 + CODE_W'(k);
      if (k >= 16'h0041 && k <= 16'h005a) return 18'h30020 + CODE_W'(k);
      return keypad_event(k);
    endfunction

    // Only family-1 codes own a special-down flag.
    function void mark_special(logic [CODE_W-1:0] c, logic v);
      if (c[CODE_W-1:16] == 2'b01 && c[15:0] < SPECIAL_KEYS) begin
        special_down[c[15:0]] = v;
      end
    endfunction

    // A full ring is overwritten without notice.
    function void push_event(logic [CODE_W-1:0] c);
      ring_code[wr_ptr]  = c;
      ring_state[wr_ptr] = mod_mask;
      wr_ptr             = (wr_ptr + 1) % RING_DEPTH;
    endfunction

    // Apply one accepted request and record the result it owes.
    function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] k);
      event_result_t    r;
      logic [MOD_W-1:0] m;
      logic [CODE_W-1:0] c;
      int               slot;
      r = '0;
      case (op)
        OP_KEY_DOWN: begin
          m    = mod_bits(k);
          slot = lock_slot(k);
          if (m != '0) begin
            mod_mask[MOD_W-1:0] |= m;
          end else if (slot >= 0) begin
            // Each lock toggles once per press until its latch is released.
            if (!lock_latch[slot]) begin
              lock_latch[slot]          = 1'b1;
              mod_mask[LOCK_LSB + slot] = ~mod_mask[LOCK_LSB + slot];
            end
          end else begin
            c = press_event(k);
            if (c != '0) begin
              push_event(c);
              mark_special(c, 1'b1);
            end
          end
        end
        OP_KEY_UP: begin
          m = mod_bits(k);
          if (m != '0) begin
            // Releasing any shift key drops caps as well.
            mod_mask[MOD_W-1:0] &= ~m;
            if (m[1:0] != '0) mod_mask[CAPS_BIT] = 1'b0;
          end else if (k == KEY_NUM) begin
            lock_latch[0] = 1'b0;
          end else if (k == KEY_SCROLL) begin
            lock_latch[1] = 1'b0;
          end else begin
            c = nav_event(k);
            if (c == '0) c = keypad_event(k);
            mark_special(c, 1'b0);
          end
        end
        OP_CHAR: begin
          c = CODE_W'(k);
          if (mod_mask[3:2] != '0 && k < CTRL_CHAR_LIMIT) c += CODE_W'(CTRL_CHAR_OFS);
          push_event(c);
        end
        OP_READ: begin
          if (rd_ptr != wr_ptr) begin
            r.ev_valid = 1'b1;
            r.code     = ring_code[rd_ptr];
            r.state    = ring_state[rd_ptr];
            rd_ptr     = (rd_ptr + 1) % RING_DEPTH;
          end else begin
            r.empty = 1'b1;
          end
        end
        OP_FLUSH: wr_ptr = rd_ptr;
        default: ;
      endcase
      pending_events.push_back(r);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
      end
    endfunction

    // Compare one result with the oldest result owed.
    function void check_result(event_result_t got);
      event_result_t want;
      if (pending_events.size() == 0) begin
        report("result with no request waiting", '0, got.code);
        return;
      end
      want = pending_events.pop_front();
      if (got.ev_valid !== want.ev_valid) report("event_valid", want.ev_valid, got.ev_valid);
      if (got.empty !== want.empty) report("ring_empty", want.empty, got.empty);
      if (got.code !== want.code) report("event_code", want.code, got.code);
      if (got.state !== want.state) report("event_state", want.state, got.state);
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [OP_W-1:0]    op_i        = '0;
  logic [KEY_W-1:0]   code_i      = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               event_valid_o;
  logic               ring_empty_o;
  logic [CODE_W-1:0]  event_code_o;
  logic [STATE_W-1:0] event_state_o;

  key_event_ring_model ring_model;
  int unsigned         tx_idle_pct   = 0;
  int unsigned         rx_stall_pct  = 0;
  int unsigned         requests_sent = 0;
  int unsigned         cycle_count   = 0;

  keyboard_event_encoder_queue #(
    .RING_DEPTH  (RING_DEPTH),
    .SPECIAL_KEYS(SPECIAL_KEYS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .code_i       (code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_valid_o(event_valid_o),
    .ring_empty_o (ring_empty_o),
    .event_code_o (event_code_o),
    .event_state_o(event_state_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Random back-pressure on the result channel.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Both handshakes are sampled at the same edge; requests are noted first.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) ring_model.note_request(op_i, code_i);
    if (out_valid_o && out_ready_i) begin
      ring_model.check_result('{event_valid_o, ring_empty_o, event_code_o, event_state_o});
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one request, after an optional random gap, and hold it until taken.
  task automatic send(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    code_i     <= k;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op <= OP_FLUSH) requests_sent++;
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ring_model.pending_events.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] random_char();
    case ($urandom_range(2))
      0:       return KEY_W'($urandom_range(0, 16'h001f));
      1:       return KEY_W'($urandom_range(16'h0020, 16'h007e));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Press and release of an ordinary key, sometimes with a character between.
  task automatic keystroke();
    logic [KEY_W-1:0] k;
    if ($urandom_range(1) == 0) k = ODD_KEYS[$urandom_range(7)];
    else k = KEY_W'($urandom_range(16'h0020, 16'h007b));
    send(OP_KEY_DOWN, k);
    if ($urandom_range(2) == 0) send(OP_CHAR, random_char());
    send(OP_KEY_UP, k);
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned     start;
    int unsigned     pick;
    logic [KEY_W-1:0] k;
    start = requests_sent;
    while (requests_sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        keystroke();
      end else if (pick < 50) begin
        // Modifier held over a few keystrokes.
        k = MODIFIER_KEYS[$urandom_range(8)];
        send(OP_KEY_DOWN, k);
        repeat ($urandom_range(1, 3)) keystroke();
        send(OP_KEY_UP, k);
      end else if (pick < 58) begin
        k = LOCK_KEYS[$urandom_range(2)];
        send(OP_KEY_DOWN, k);
        if ($urandom_range(3) != 0) send(OP_KEY_UP, k);
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 12)) send(OP_READ, KEY_W'($urandom));
      end else if (pick < 88) begin
        // Long burst of characters that can wrap the ring.
        repeat ($urandom_range(30, 70)) send(OP_CHAR, random_char());
      end else if (pick < 93) begin
        send(OP_W'($urandom_range(OP_KEY_DOWN, OP_FLUSH)), KEY_W'($urandom));
      end else if (pick < 96) begin
        send(OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), KEY_W'($urandom));
      end else if (pick < 98) begin
        send(OP_FLUSH, KEY_W'($urandom));
      end else begin
        wait_for_drain();
      end
    end
  endtask

  // Main sequence: reset, directed requests, then three random phases.
  initial begin
    ring_model = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct  = 10;
    rx_stall_pct = 81;

    // Empty ring, flush and the extremes of the key field.
    send(OP_READ, '0);
    send(OP_FLUSH, '0);
    send(OP_KEY_DOWN, 16'h0000);
    send(OP_KEY_UP, 16'hffff);
    send(OP_CHAR, 16'hffff);
    // Control characters below escape are shifted up, escape itself is not.
    send(OP_KEY_DOWN, VK_CTRL);
    send(OP_CHAR, 16'h0000);
    send(OP_CHAR, 16'h001a);
    send(OP_CHAR, CTRL_CHAR_LIMIT);
    send(OP_KEY_UP, VK_CTRL);
    // Caps toggles only on its first press, as its latch stays set; shift release clears it.
    send(OP_KEY_DOWN, VK_SHIFT);
    send(OP_KEY_DOWN, KEY_CAPS);
    send(OP_KEY_UP, KEY_CAPS);
    send(OP_KEY_DOWN, KEY_CAPS);
    send(OP_KEY_DOWN, VK_A);
    send(OP_KEY_UP, VK_SHIFT);
    // Num latch is released, so a second press toggles back.
    send(OP_KEY_DOWN, KEY_NUM);
    send(OP_KEY_UP, KEY_NUM);
    send(OP_KEY_DOWN, KEY_NUM);
    send(OP_KEY_DOWN, KEY_SCROLL);
    // Function key, then escape and a keypad digit, each pressed and released.
    send(OP_KEY_DOWN, VK_F12);
    send(OP_KEY_DOWN, VK_ESC);
    send(OP_KEY_UP, VK_ESC);
    send(OP_KEY_DOWN, VK_PAD0);
    send(OP_KEY_UP, VK_PAD0);
    send(OP_LAST_UNUSED, 16'hffff);
    repeat (10) send(OP_READ, '0);
    wait_for_drain();

    random_phase(200);
    wait_for_drain();
    tx_idle_pct  = 81;
    rx_stall_pct = 10;
    random_phase(200);
    wait_for_drain();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    random_phase(200);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ring_model.mismatches == 0 && ring_model.pending_events.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
